// ===== hdl/motor_frame_transform_top_macros.svh =====
// Assertion macros for the motor frame transform block.
`ifndef MOTOR_FRAME_TRANSFORM_TOP_MACROS_SVH
`define MOTOR_FRAME_TRANSFORM_TOP_MACROS_SVH

// same-cycle implication
`define MFT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("motor_frame_transform: same-cycle check failed");

// next-cycle implication
`define MFT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("motor_frame_transform: next-cycle check failed");

`endif

// ===== hdl/mft_pkg.sv =====
// Shared constants, types and the sine table builder for the frame transform.
package mft_pkg;

	localparam int DATA_WIDTH      = 16;
	localparam int ANGLE_WIDTH     = 16;
	localparam int SINE_TABLE_BITS = 10;

	localparam int MODE_W  = 3;
	localparam int N_LANES = 3;
	localparam int N_OPS   = 3;

	localparam int IN_TDATA_W  = ((N_OPS * DATA_WIDTH + ANGLE_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((N_LANES * DATA_WIDTH + 7) / 8) * 8;

	// Q1.15 constants
	localparam int K_W = 16;
	localparam logic [K_W-1:0] K_ONE        = 16'd32768;
	localparam logic [K_W-1:0] K_SQ23       = 16'd26755;
	localparam logic [K_W-1:0] K_SQ23_HALF  = 16'd13377;
	localparam logic [K_W-1:0] K_INV_SQRT2  = 16'd23170;
	localparam logic [K_W-1:0] K_HALF       = 16'd16384;
	localparam logic [K_W-1:0] K_SQRT3_HALF = 16'd28378;
	localparam logic [K_W-1:0] K_THIRD      = 16'd10923;
	localparam logic [K_W-1:0] K_TWO_THIRDS = 16'd21845;
	localparam logic [K_W-1:0] K_INV_SQRT3  = 16'd18919;

	// sine table: magnitude 0..32768
	localparam int SINE_W    = 16;
	localparam int SC_W      = SINE_W + 1;
	localparam int P_BITS    = SINE_TABLE_BITS + 2;
	localparam int ROM_AW    = SINE_TABLE_BITS + 1;
	localparam int ROM_DEPTH = (1 << SINE_TABLE_BITS) + 1;
	localparam logic [ROM_AW-1:0] ROM_FULL = ROM_AW'(1) << SINE_TABLE_BITS;

	// Q2.30 datapath
	localparam int COEF_W    = 32;
	localparam int FRAC_BITS = 30;
	localparam int PROD_W    = COEF_W + DATA_WIDTH;
	localparam int ACC_W     = PROD_W + 2;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [COEF_W-1:0]     coef_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [ACC_W-1:0]      acc_t;
	typedef logic [SINE_W-1:0]            sine_t;
	typedef sine_t                        sine_rom_t [ROM_DEPTH];

	localparam data_t DATA_MAX = data_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
	localparam data_t DATA_MIN = data_t'({1'b1, {(DATA_WIDTH-1){1'b0}}});
	localparam acc_t  ACC_DMAX = acc_t'(DATA_MAX);
	localparam acc_t  ACC_DMIN = acc_t'(DATA_MIN);
	localparam acc_t  ACC_ROUND = acc_t'(64'd1 << (FRAC_BITS - 1));

	typedef enum logic [MODE_W-1:0] {
		MODE_CLARKE     = 3'd0,
		MODE_ABC_DQ     = 3'd1,
		MODE_INV_CLARKE = 3'd2,
		MODE_PARK       = 3'd3,
		MODE_DQ_ABC     = 3'd4,
		MODE_INV_PARK   = 3'd5
	} mode_t;

	// load enables, one per pipeline stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
	localparam logic [63:0] HORNER_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

	// truncating Q2.30 Horner series to x^13, rounded to Q1.15 and capped at one
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] r;
		for (int k = 0; k < ROM_DEPTH; k++) begin
			x  = (64'(k) * PI_HALF_Q30) >> SINE_TABLE_BITS;
			x2 = (x * x) >> 30;
			t  = ONE_Q30;
			for (int i = 0; i < 6; i++) begin
				t = ONE_Q30 - (((x2 * t) >> 30) / HORNER_DIV[i]);
			end
			s = (x * t) >> 30;
			r = (s + 64'd16384) >> 15;
			if (r > 64'(K_ONE)) begin
				r = 64'(K_ONE);
			end
			rom[k] = SINE_W'(r);
		end
		return rom;
	endfunction

endpackage

// ===== hdl/mft_sine_rom.sv =====
// Quarter-wave sine table with two registered read ports for sine and cosine.
module mft_sine_rom (
	input  logic                                 clk,
	input  mft_pkg::stage_en_t                   en,
	input  logic [mft_pkg::ANGLE_WIDTH-1:0]      angle,
	output mft_pkg::sine_t                       sin_mag_s1,
	output logic                                 sin_neg_s1,
	output mft_pkg::sine_t                       cos_mag_s1,
	output logic                                 cos_neg_s1
);

	localparam mft_pkg::sine_rom_t SINE_ROM = mft_pkg::build_sine_rom();

	logic [mft_pkg::ANGLE_WIDTH+mft_pkg::P_BITS-1:0] ang_ext;
	logic [mft_pkg::P_BITS-1:0]                      phase;
	logic [mft_pkg::SINE_TABLE_BITS-1:0]             frac;
	logic [1:0]                                      sin_quad;
	logic [1:0]                                      cos_quad;
	logic [mft_pkg::ROM_AW-1:0]                      sin_idx;
	logic [mft_pkg::ROM_AW-1:0]                      cos_idx;

	always_comb begin
		ang_ext  = {angle, mft_pkg::P_BITS'(0)};
		phase    = ang_ext[mft_pkg::ANGLE_WIDTH+mft_pkg::P_BITS-1 -: mft_pkg::P_BITS];
		frac     = phase[mft_pkg::SINE_TABLE_BITS-1:0];
		sin_quad = phase[mft_pkg::P_BITS-1 -: 2];
		cos_quad = sin_quad + 2'd1;
		sin_idx  = sin_quad[0] ? (mft_pkg::ROM_FULL - {1'b0, frac}) : {1'b0, frac};
		cos_idx  = cos_quad[0] ? (mft_pkg::ROM_FULL - {1'b0, frac}) : {1'b0, frac};
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			sin_mag_s1 <= SINE_ROM[sin_idx];
			cos_mag_s1 <= SINE_ROM[cos_idx];
			sin_neg_s1 <= sin_quad[1];
			cos_neg_s1 <= cos_quad[1];
		end
	end

endmodule

// ===== hdl/mft_coef.sv =====
// Per-mode Q2.30 coefficient matrix built from sine and cosine.
module mft_coef (
	input  logic               clk,
	input  mft_pkg::stage_en_t en,
	input  mft_pkg::mode_t     mode_s1,
	input  mft_pkg::sine_t     sin_mag_s1,
	input  logic               sin_neg_s1,
	input  mft_pkg::sine_t     cos_mag_s1,
	input  logic               cos_neg_s1,
	output mft_pkg::coef_t     coef_s2 [mft_pkg::N_LANES][mft_pkg::N_OPS]
);

	function automatic mft_pkg::coef_t kmul(input logic [mft_pkg::K_W-1:0] k,
			input logic signed [mft_pkg::SC_W-1:0] v);
		logic signed [mft_pkg::K_W+mft_pkg::SC_W:0] p;
		p = $signed({1'b0, k}) * v;
		return mft_pkg::coef_t'(p);
	endfunction

	logic signed [mft_pkg::SC_W-1:0] sv;
	logic signed [mft_pkg::SC_W-1:0] cv;
	logic signed [mft_pkg::SC_W-1:0] one_v;
	mft_pkg::coef_t                  coef_d [mft_pkg::N_LANES][mft_pkg::N_OPS];

	always_comb begin
		sv    = sin_neg_s1 ? -$signed({1'b0, sin_mag_s1}) : $signed({1'b0, sin_mag_s1});
		cv    = cos_neg_s1 ? -$signed({1'b0, cos_mag_s1}) : $signed({1'b0, cos_mag_s1});
		one_v = mft_pkg::SC_W'(mft_pkg::K_ONE);
		for (int i = 0; i < mft_pkg::N_LANES; i++) begin
			for (int j = 0; j < mft_pkg::N_OPS; j++) begin
				coef_d[i][j] = '0;
			end
		end
		case (mode_s1)
			mft_pkg::MODE_CLARKE: begin
				coef_d[0][0] = kmul(mft_pkg::K_SQ23, one_v);
				coef_d[0][1] = -kmul(mft_pkg::K_SQ23_HALF, one_v);
				coef_d[0][2] = -kmul(mft_pkg::K_SQ23_HALF, one_v);
				coef_d[1][1] = kmul(mft_pkg::K_INV_SQRT2, one_v);
				coef_d[1][2] = -kmul(mft_pkg::K_INV_SQRT2, one_v);
			end
			mft_pkg::MODE_ABC_DQ: begin
				coef_d[0][0] = kmul(mft_pkg::K_TWO_THIRDS, cv);
				coef_d[0][1] = kmul(mft_pkg::K_INV_SQRT3, sv) - kmul(mft_pkg::K_THIRD, cv);
				coef_d[0][2] = -kmul(mft_pkg::K_THIRD, cv) - kmul(mft_pkg::K_INV_SQRT3, sv);
				coef_d[1][0] = -kmul(mft_pkg::K_TWO_THIRDS, sv);
				coef_d[1][1] = kmul(mft_pkg::K_THIRD, sv) + kmul(mft_pkg::K_INV_SQRT3, cv);
				coef_d[1][2] = kmul(mft_pkg::K_THIRD, sv) - kmul(mft_pkg::K_INV_SQRT3, cv);
			end
			mft_pkg::MODE_INV_CLARKE: begin
				coef_d[0][0] = kmul(mft_pkg::K_SQ23, one_v);
				coef_d[1][0] = -kmul(mft_pkg::K_SQ23_HALF, one_v);
				coef_d[1][1] = kmul(mft_pkg::K_INV_SQRT2, one_v);
				coef_d[2][0] = -kmul(mft_pkg::K_SQ23_HALF, one_v);
				coef_d[2][1] = -kmul(mft_pkg::K_INV_SQRT2, one_v);
			end
			mft_pkg::MODE_PARK: begin
				coef_d[0][0] = kmul(mft_pkg::K_ONE, cv);
				coef_d[0][1] = kmul(mft_pkg::K_ONE, sv);
				coef_d[1][0] = -kmul(mft_pkg::K_ONE, sv);
				coef_d[1][1] = kmul(mft_pkg::K_ONE, cv);
			end
			mft_pkg::MODE_DQ_ABC: begin
				coef_d[0][0] = kmul(mft_pkg::K_ONE, cv);
				coef_d[0][1] = -kmul(mft_pkg::K_ONE, sv);
				coef_d[1][0] = kmul(mft_pkg::K_SQRT3_HALF, sv) - kmul(mft_pkg::K_HALF, cv);
				coef_d[1][1] = kmul(mft_pkg::K_HALF, sv) + kmul(mft_pkg::K_SQRT3_HALF, cv);
				coef_d[2][0] = -kmul(mft_pkg::K_HALF, cv) - kmul(mft_pkg::K_SQRT3_HALF, sv);
				coef_d[2][1] = kmul(mft_pkg::K_HALF, sv) - kmul(mft_pkg::K_SQRT3_HALF, cv);
			end
			mft_pkg::MODE_INV_PARK: begin
				coef_d[0][0] = kmul(mft_pkg::K_ONE, cv);
				coef_d[0][1] = -kmul(mft_pkg::K_ONE, sv);
				coef_d[1][0] = kmul(mft_pkg::K_ONE, sv);
				coef_d[1][1] = kmul(mft_pkg::K_ONE, cv);
			end
			default: begin
				// undefined modes keep an all-zero matrix
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			coef_s2 <= coef_d;
		end
	end

endmodule

// ===== hdl/mft_lane.sv =====
// One output lane: three products, then the rounded sum.
module mft_lane (
	input  logic               clk,
	input  mft_pkg::stage_en_t en,
	input  mft_pkg::coef_t     coef_s2 [mft_pkg::N_OPS],
	input  mft_pkg::data_t     x_s2 [mft_pkg::N_OPS],
	output mft_pkg::acc_t      acc_s4
);

	mft_pkg::prod_t prod_s3 [mft_pkg::N_OPS];
	mft_pkg::acc_t  acc_d;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int j = 0; j < mft_pkg::N_OPS; j++) begin
				prod_s3[j] <= coef_s2[j] * x_s2[j];
			end
		end
	end

	always_comb begin
		acc_d = mft_pkg::ACC_ROUND;
		for (int j = 0; j < mft_pkg::N_OPS; j++) begin
			acc_d = acc_d + mft_pkg::acc_t'(prod_s3[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			acc_s4 <= acc_d;
		end
	end

endmodule

// ===== hdl/mft_merge.sv =====
// Scales and clips the lane sums and merges their clip flags into the output register.
module mft_merge (
	input  logic               clk,
	input  mft_pkg::stage_en_t en,
	input  mft_pkg::acc_t      acc_s4 [mft_pkg::N_LANES],
	output mft_pkg::data_t     res_s5 [mft_pkg::N_LANES],
	output logic               sat_s5
);

	mft_pkg::acc_t  q      [mft_pkg::N_LANES];
	mft_pkg::data_t res_d  [mft_pkg::N_LANES];
	logic           sat_d;

	always_comb begin
		sat_d = 1'b0;
		for (int i = 0; i < mft_pkg::N_LANES; i++) begin
			q[i] = acc_s4[i] >>> mft_pkg::FRAC_BITS;
			if (q[i] > mft_pkg::ACC_DMAX) begin
				res_d[i] = mft_pkg::DATA_MAX;
				sat_d    = 1'b1;
			end else if (q[i] < mft_pkg::ACC_DMIN) begin
				res_d[i] = mft_pkg::DATA_MIN;
				sat_d    = 1'b1;
			end else begin
				res_d[i] = q[i][mft_pkg::DATA_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			res_s5 <= res_d;
			sat_s5 <= sat_d;
		end
	end

endmodule

// ===== hdl/motor_frame_transform_top.sv =====
// Top level of the Clarke/Park frame transform pipeline.
//
//  channel  dir  fields (low bit up)
//  s_       in   tdata: in_first, in_second, in_third, angle   tuser: mode
//  m_       out  tdata: out_first, out_second, out_third        tuser: saturated
//
// One transfer per cycle in and out unless m_tready holds the output back.
// Stages: table read, coefficients, lane products, lane sums, clip and merge.
// The 1025-entry sine table is a constant ROM read at two addresses per cycle.
// Reset clears only the stage valid bits; no clearing pass is needed.
// A stage loads whenever it is empty or its successor loads, so bubbles close up
// while the output waits.
module motor_frame_transform_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// in_first, in_second, in_third, angle
	input  logic [mft_pkg::IN_TDATA_W-1:0]     s_tdata,
	// mode
	input  logic [mft_pkg::MODE_W-1:0]         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// out_first, out_second, out_third
	output logic [mft_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// saturated
	output logic [0:0]                         m_tuser
);

	localparam int DW = mft_pkg::DATA_WIDTH;

	mft_pkg::stage_en_t en;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	mft_pkg::mode_t     mode_s1;
	mft_pkg::mode_t     mode_s2;
	mft_pkg::data_t     x_in [mft_pkg::N_OPS];
	mft_pkg::data_t     x_s1 [mft_pkg::N_OPS];
	mft_pkg::data_t     x_s2 [mft_pkg::N_OPS];
	mft_pkg::sine_t     sin_mag_s1, cos_mag_s1;
	logic               sin_neg_s1, cos_neg_s1;
	mft_pkg::coef_t     coef_s2 [mft_pkg::N_LANES][mft_pkg::N_OPS];
	mft_pkg::acc_t      acc_s4 [mft_pkg::N_LANES];
	mft_pkg::data_t     res_s5 [mft_pkg::N_LANES];
	logic               sat_s5;

	always_comb begin
		en.s5 = !v_s5 || m_tready;
		en.s4 = !v_s4 || en.s5;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign s_tready = en.s1;
	assign m_tvalid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= s_tvalid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
		end
	end

	always_comb begin
		for (int j = 0; j < mft_pkg::N_OPS; j++) begin
			x_in[j] = s_tdata[j*DW +: DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			mode_s1 <= mft_pkg::mode_t'(s_tuser);
			x_s1    <= x_in;
		end
		if (en.s2) begin
			mode_s2 <= mode_s1;
			x_s2    <= x_s1;
		end
	end

	mft_sine_rom u_rom (
		.clk        (clk),
		.en         (en),
		.angle      (s_tdata[mft_pkg::N_OPS*DW +: mft_pkg::ANGLE_WIDTH]),
		.sin_mag_s1 (sin_mag_s1),
		.sin_neg_s1 (sin_neg_s1),
		.cos_mag_s1 (cos_mag_s1),
		.cos_neg_s1 (cos_neg_s1)
	);

	mft_coef u_coef (
		.clk        (clk),
		.en         (en),
		.mode_s1    (mode_s1),
		.sin_mag_s1 (sin_mag_s1),
		.sin_neg_s1 (sin_neg_s1),
		.cos_mag_s1 (cos_mag_s1),
		.cos_neg_s1 (cos_neg_s1),
		.coef_s2    (coef_s2)
	);

	for (genvar i = 0; i < mft_pkg::N_LANES; i++) begin : g_lane
		mft_lane u_lane (
			.clk     (clk),
			.en      (en),
			.coef_s2 (coef_s2[i]),
			.x_s2    (x_s2),
			.acc_s4  (acc_s4[i])
		);
	end

	mft_merge u_merge (
		.clk    (clk),
		.en     (en),
		.acc_s4 (acc_s4),
		.res_s5 (res_s5),
		.sat_s5 (sat_s5)
	);

	assign m_tdata = mft_pkg::OUT_TDATA_W'({res_s5[2], res_s5[1], res_s5[0]});
	assign m_tuser = sat_s5;

	`include "motor_frame_transform_top_macros.svh"

	`MFT_ASSERT_NOW(a_full_when_blocked, !s_tready, v_s1 && v_s2 && v_s3 && v_s4 && v_s5)
	`MFT_ASSERT_NEXT(a_sum_held_on_stall, v_s4 && v_s5 && !m_tready, v_s4 && v_s5)
	`MFT_ASSERT_NOW(a_third_lane_idle, v_s2 && (mode_s2 == mft_pkg::MODE_CLARKE || mode_s2 == mft_pkg::MODE_ABC_DQ || mode_s2 == mft_pkg::MODE_PARK || mode_s2 == mft_pkg::MODE_INV_PARK), coef_s2[2][0] == '0 && coef_s2[2][1] == '0 && coef_s2[2][2] == '0)
	`MFT_ASSERT_NOW(a_clip_at_rail, v_s5 && sat_s5, res_s5[0] == mft_pkg::DATA_MAX || res_s5[0] == mft_pkg::DATA_MIN || res_s5[1] == mft_pkg::DATA_MAX || res_s5[1] == mft_pkg::DATA_MIN || res_s5[2] == mft_pkg::DATA_MAX || res_s5[2] == mft_pkg::DATA_MIN)

endmodule

// ===== tb/sv/motor_frame_transform_top_tb.sv =====
// Self-checking testbench for the Clarke/Park frame transform pipeline.
module motor_frame_transform_top_tb;
	import mft_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int IDLE_PCT     = 8;

	localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RSVD_HI = 3'd7;

	// Q1.15 constants and pi/2 in Q2.30
	localparam longint Q_ONE       = 32768;
	localparam longint Q_SQ23      = 26755;
	localparam longint Q_SQ23_HALF = 13377;
	localparam longint Q_INV_SQRT2 = 23170;
	localparam longint Q_HALF      = 16384;
	localparam longint Q_SQ3_HALF  = 28378;
	localparam longint Q_THIRD     = 10923;
	localparam longint Q_TWO_THIRD = 21845;
	localparam longint Q_INV_SQRT3 = 18919;
	localparam longint unsigned Q30_PI_HALF = 64'd1686629713;
	localparam longint unsigned Q30_ONE     = 64'd1 << 30;
	localparam longint unsigned SERIES_DIV [6] = '{156, 110, 72, 42, 20, 6};

	typedef struct {
		logic [MODE_W-1:0]      mode;
		data_t                  in_first;
		data_t                  in_second;
		data_t                  in_third;
		logic [ANGLE_WIDTH-1:0] angle;
	} frame_in_t;

	typedef struct {
		data_t out_first;
		data_t out_second;
		data_t out_third;
		logic  saturated;
	} frame_out_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [MODE_W-1:0]      s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [0:0]             m_tuser;

	frame_out_t expected_frames [$];
	int         error_count = 0;
	int         cycle_count = 0;
	logic       quiet_run   = 1'b0;

	motor_frame_transform_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #CLK_HALF clk = ~clk;

	// quarter-wave magnitude, truncating Horner series in Q2.30
	function automatic longint quarter_sine(longint unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned r;
		x  = (k * Q30_PI_HALF) >> SINE_TABLE_BITS;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		for (int i = 0; i < 6; i++) begin
			t = Q30_ONE - (((x2 * t) >> 30) / SERIES_DIV[i]);
		end
		s = (x * t) >> 30;
		r = (s + 64'd16384) >> 15;
		if (r > longint'(Q_ONE)) begin
			r = Q_ONE;
		end
		return longint'(r);
	endfunction

	function automatic longint signed_sine(logic [P_BITS-1:0] p);
		longint unsigned k;
		longint          mag;
		k   = p[SINE_TABLE_BITS-1:0];
		mag = p[SINE_TABLE_BITS] ? quarter_sine((64'd1 << SINE_TABLE_BITS) - k)
			: quarter_sine(k);
		return p[SINE_TABLE_BITS+1] ? -mag : mag;
	endfunction

	// round half up from Q2.30, clip; top bit flags a clip
	function automatic logic [DATA_WIDTH:0] round_clip(longint acc);
		longint q;
		q = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (q > longint'(DATA_MAX)) begin
			return {1'b1, DATA_MAX};
		end
		if (q < longint'(DATA_MIN)) begin
			return {1'b1, DATA_MIN};
		end
		return {1'b0, q[DATA_WIDTH-1:0]};
	endfunction

	function automatic frame_out_t predict_frame(frame_in_t it);
		frame_out_t          res;
		longint              xa;
		longint              xb;
		longint              xc;
		longint              sn;
		longint              cs;
		logic [P_BITS-1:0]   p;
		logic [DATA_WIDTH:0] r0;
		logic [DATA_WIDTH:0] r1;
		logic [DATA_WIDTH:0] r2;
		xa = it.in_first;
		xb = it.in_second;
		xc = it.in_third;
		p  = it.angle[ANGLE_WIDTH-1 -: P_BITS];
		sn = signed_sine(p);
		cs = signed_sine(p + P_BITS'(1 << SINE_TABLE_BITS));
		r0 = '0;
		r1 = '0;
		r2 = '0;
		case (it.mode)
			MODE_CLARKE: begin
				r0 = round_clip(Q_SQ23 * Q_ONE * xa - Q_SQ23_HALF * Q_ONE * xb
					- Q_SQ23_HALF * Q_ONE * xc);
				r1 = round_clip(Q_INV_SQRT2 * Q_ONE * xb - Q_INV_SQRT2 * Q_ONE * xc);
			end
			MODE_ABC_DQ: begin
				r0 = round_clip(Q_TWO_THIRD * cs * xa
					+ (-Q_THIRD * cs + Q_INV_SQRT3 * sn) * xb
					+ (-Q_THIRD * cs - Q_INV_SQRT3 * sn) * xc);
				r1 = round_clip(-Q_TWO_THIRD * sn * xa
					+ (Q_THIRD * sn + Q_INV_SQRT3 * cs) * xb
					+ (Q_THIRD * sn - Q_INV_SQRT3 * cs) * xc);
			end
			MODE_INV_CLARKE: begin
				r0 = round_clip(Q_SQ23 * Q_ONE * xa);
				r1 = round_clip(-Q_SQ23_HALF * Q_ONE * xa + Q_INV_SQRT2 * Q_ONE * xb);
				r2 = round_clip(-Q_SQ23_HALF * Q_ONE * xa - Q_INV_SQRT2 * Q_ONE * xb);
			end
			MODE_PARK: begin
				r0 = round_clip(cs * Q_ONE * xa + sn * Q_ONE * xb);
				r1 = round_clip(-sn * Q_ONE * xa + cs * Q_ONE * xb);
			end
			MODE_DQ_ABC: begin
				r0 = round_clip(cs * Q_ONE * xa - sn * Q_ONE * xb);
				r1 = round_clip((-Q_HALF * cs + Q_SQ3_HALF * sn) * xa
					+ (Q_HALF * sn + Q_SQ3_HALF * cs) * xb);
				r2 = round_clip((-Q_HALF * cs - Q_SQ3_HALF * sn) * xa
					+ (Q_HALF * sn - Q_SQ3_HALF * cs) * xb);
			end
			MODE_INV_PARK: begin
				r0 = round_clip(cs * Q_ONE * xa - sn * Q_ONE * xb);
				r1 = round_clip(sn * Q_ONE * xa + cs * Q_ONE * xb);
			end
			default: begin
			end
		endcase
		res.out_first  = r0[DATA_WIDTH-1:0];
		res.out_second = r1[DATA_WIDTH-1:0];
		res.out_third  = r2[DATA_WIDTH-1:0];
		res.saturated  = r0[DATA_WIDTH] | r1[DATA_WIDTH] | r2[DATA_WIDTH];
		return res;
	endfunction

	function automatic frame_in_t make_frame(logic [MODE_W-1:0] mode, data_t a, data_t b,
			data_t c, logic [ANGLE_WIDTH-1:0] angle);
		frame_in_t it;
		it.mode      = mode;
		it.in_first  = a;
		it.in_second = b;
		it.in_third  = c;
		it.angle     = angle;
		return it;
	endfunction

	function automatic data_t rand_operand();
		int pick;
		pick = $urandom_range(99);
		if (pick < 8) begin
			return DATA_MAX;
		end
		if (pick < 16) begin
			return DATA_MIN;
		end
		if (pick < 20) begin
			return data_t'($urandom_range(2)) - data_t'(1);
		end
		return data_t'($urandom);
	endfunction

	function automatic logic [ANGLE_WIDTH-1:0] rand_angle();
		logic [ANGLE_WIDTH-1:0] quad;
		if ($urandom_range(99) < 20) begin
			quad = ANGLE_WIDTH'($urandom_range(3)) << (ANGLE_WIDTH - 2);
			return quad + ANGLE_WIDTH'($urandom_range(63)) - ANGLE_WIDTH'(32);
		end
		return ANGLE_WIDTH'($urandom);
	endfunction

	task automatic send_frame(frame_in_t it);
		logic taken;
		while (!quiet_run && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'({it.angle, it.in_third, it.in_second, it.in_first});
		s_tuser  <= it.mode;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		expected_frames.push_back(predict_frame(it));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_frames.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic test_each_mode();
		for (int m = 0; m < 8; m++) begin
			send_frame(make_frame(MODE_W'(m), 16'sd12000, -16'sd7000, 16'sd3000, 16'h2345));
		end
	endtask

	task automatic test_field_extremes();
		send_frame(make_frame(MODE_CLARKE, DATA_MAX, DATA_MIN, DATA_MIN, 16'h0000));
		send_frame(make_frame(MODE_CLARKE, DATA_MIN, DATA_MAX, DATA_MAX, 16'hFFFF));
		send_frame(make_frame(MODE_ABC_DQ, DATA_MAX, DATA_MIN, DATA_MIN, 16'h4000));
		// third operand must be ignored
		send_frame(make_frame(MODE_INV_CLARKE, DATA_MIN, DATA_MAX, 16'sd12345, 16'hFFFF));
		send_frame(make_frame(MODE_PARK, DATA_MIN, DATA_MIN, DATA_MAX, 16'hFFFF));
		send_frame(make_frame(MODE_DQ_ABC, DATA_MAX, DATA_MAX, DATA_MIN, 16'h1000));
		send_frame(make_frame(MODE_INV_PARK, DATA_MAX, DATA_MIN, -16'sd1, 16'h0000));
		// undefined modes return zero
		send_frame(make_frame(MODE_RSVD_LO, -16'sd1, -16'sd1, -16'sd1, 16'hFFFF));
		send_frame(make_frame(MODE_RSVD_HI, DATA_MAX, DATA_MIN, DATA_MAX, 16'h8000));
	endtask

	task automatic test_quadrant_edges();
		logic [ANGLE_WIDTH-1:0] edges [6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
			16'h3FFF, 16'hFFF0};
		for (int i = 0; i < 6; i++) begin
			send_frame(make_frame(MODE_PARK, 16'sd20000, -16'sd10000, DATA_MIN, edges[i]));
		end
	endtask

	task automatic test_random_traffic(int count);
		logic [MODE_W-1:0] mode;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 8) begin
				mode = $urandom_range(1) ? MODE_RSVD_HI : MODE_RSVD_LO;
			end else begin
				mode = MODE_W'($urandom_range(5));
			end
			send_frame(make_frame(mode, rand_operand(), rand_operand(), rand_operand(),
				rand_angle()));
		end
	endtask

	task automatic test_drain_pause();
		test_random_traffic(30);
		wait_drained();
		test_random_traffic(30);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet_run || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// handshake inputs are stable from the falling edge to the next rising edge
	always @(negedge clk) begin
		frame_out_t got;
		frame_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.out_first  = m_tdata[DATA_WIDTH-1:0];
			got.out_second = m_tdata[2*DATA_WIDTH-1 -: DATA_WIDTH];
			got.out_third  = m_tdata[3*DATA_WIDTH-1 -: DATA_WIDTH];
			got.saturated  = m_tuser[0];
			if (expected_frames.size() == 0) begin
				$error("result transfer with nothing expected");
				error_count++;
			end else begin
				want = expected_frames.pop_front();
				if (got.out_first !== want.out_first) begin
					$error("out_first: expected %0d, actual %0d", want.out_first, got.out_first);
					error_count++;
				end
				if (got.out_second !== want.out_second) begin
					$error("out_second: expected %0d, actual %0d", want.out_second,
						got.out_second);
					error_count++;
				end
				if (got.out_third !== want.out_third) begin
					$error("out_third: expected %0d, actual %0d", want.out_third, got.out_third);
					error_count++;
				end
				if (got.saturated !== want.saturated) begin
					$error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("motor_frame_transform_top_tb: errors");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_each_mode();
		test_field_extremes();
		test_quadrant_edges();
		test_random_traffic(450);
		quiet_run <= 1'b1;
		test_random_traffic(300);
		quiet_run <= 1'b0;
		test_drain_pause();
		test_random_traffic(380);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("motor_frame_transform_top_tb: clean");
		end else begin
			$display("motor_frame_transform_top_tb: errors");
		end
		$finish;
	end

endmodule

// ===== motor_frame_transform_top.f =====
+incdir+hdl
hdl/mft_pkg.sv
hdl/mft_sine_rom.sv
hdl/mft_coef.sv
hdl/mft_lane.sv
hdl/mft_merge.sv
hdl/motor_frame_transform_top.sv
tb/sv/motor_frame_transform_top_tb.sv
